@@ hdl/hdwe_pkg.sv @@
// Shared types, constants and helpers for the host name wire encoder.
`default_nettype none

package hdwe_pkg;

   localparam int LABEL_MAX   = 62;
   localparam int LEN_W       = $clog2(LABEL_MAX + 1);
   localparam int BANKS       = 2;
   localparam int BANK_W      = 1;
   localparam int RAM_DEPTH   = BANKS * (1 << LEN_W);
   localparam int RAM_ADDR_W  = BANK_W + LEN_W;
   localparam int COUNT_W     = 12;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = 1;
   localparam int QCNT_W      = 2;

   localparam logic [7:0] CHAR_HYPHEN = 8'h2D;
   localparam logic [7:0] CHAR_DOT    = 8'h2E;
   localparam logic [7:0] CHAR_UP_A   = 8'h41;
   localparam logic [7:0] CHAR_UP_Z   = 8'h5A;
   localparam logic [7:0] CHAR_LO_A   = 8'h61;
   localparam logic [7:0] CHAR_LO_Z   = 8'h7A;
   localparam logic [7:0] CHAR_0      = 8'h30;
   localparam logic [7:0] CHAR_9      = 8'h39;

   localparam logic [COUNT_W-1:0] MAX_WIRE_RESET = 12'd255;

   typedef enum logic [1:0] {
      ERR_NONE   = 2'd0,
      ERR_SYNTAX = 2'd1,
      ERR_LONG   = 2'd2,
      ERR_LIMIT  = 2'd3
   } err_code_type;

   typedef enum logic [1:0] {
      SYN_START  = 2'd0,
      SYN_FIRST  = 2'd1,
      SYN_HYPHEN = 2'd2,
      SYN_ALNUM  = 2'd3
   } syntax_state_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_LEN,
      BK_CHAR,
      BK_TERM,
      BK_ERR
   } back_state_type;

   typedef struct packed {
      logic              has_label;
      logic              add_term;
      logic [BANK_W-1:0] bank;
      logic [LEN_W-1:0]  len;
      err_code_type      err;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } fifo_status_type;

   typedef struct packed {
      logic              valid;
      logic [BANK_W-1:0] bank;
   } bank_release_type;

   function automatic logic is_alnum(input logic [7:0] c);
      is_alnum = (c >= CHAR_UP_A && c <= CHAR_UP_Z) ||
                 (c >= CHAR_LO_A && c <= CHAR_LO_Z) ||
                 (c >= CHAR_0 && c <= CHAR_9);
   endfunction

endpackage

`default_nettype wire

@@ hdl/hdwe_req_if.sv @@
// Input channel: one host name character or end item per word.
`default_nettype none

interface hdwe_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_byte;
   logic       end_marker;

   modport source (output valid, output char_byte, output end_marker, input ready);
   modport sink   (input valid, input char_byte, input end_marker, output ready);
endinterface

`default_nettype wire

@@ hdl/hdwe_rsp_if.sv @@
// Result channel: one wire-format byte or error word per word.
`default_nettype none

interface hdwe_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] wire_byte;
   logic       last_of_name;
   logic [1:0] error_code;

   modport source (output valid, output wire_byte, output last_of_name,
                   output error_code, input ready);
   modport sink   (input valid, input wire_byte, input last_of_name,
                   input error_code, output ready);
endinterface

`default_nettype wire

@@ hdl/hdwe_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module hdwe_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

@@ hdl/hdwe_cmd_fifo.sv @@
// Short command queue between the classifying front and the emitting back.
`default_nettype none

module hdwe_cmd_fifo (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    push,
   input  wire hdwe_pkg::cmd_type       push_cmd,
   input  wire logic                    pop,
   output      hdwe_pkg::cmd_type       head_cmd,
   output      hdwe_pkg::fifo_status_type status
);
   import hdwe_pkg::*;

   cmd_type           entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   function automatic logic [QPTR_W-1:0] ptr_next(input logic [QPTR_W-1:0] p);
      if (p == QPTR_W'(QUEUE_DEPTH - 1)) begin
         ptr_next = '0;
      end else begin
         ptr_next = p + QPTR_W'(1);
      end
   endfunction

   always_comb begin
      wr_ptr_in = push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   assign head_cmd     = entry_ff[rd_ptr_ff];
   assign status.full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);

endmodule

`default_nettype wire

@@ hdl/hdwe_front.sv @@
// Front: accepts characters, runs the syntax machine, buffers labels, queues commands.
`default_nettype none

module hdwe_front (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_write_enable,
   input  wire logic [11:0]                   csr_write_data,
   hdwe_req_if.sink                           req,
   input  wire hdwe_pkg::fifo_status_type     fifo_status,
   input  wire hdwe_pkg::bank_release_type    release_bank,
   output      logic                          push,
   output      hdwe_pkg::cmd_type             push_cmd,
   output      logic                          ram_wr_en,
   output      logic [hdwe_pkg::RAM_ADDR_W-1:0] ram_wr_addr,
   output      logic [7:0]                    ram_wr_data
);
   import hdwe_pkg::*;

   logic [COUNT_W-1:0] max_wire_ff;
   logic [LEN_W-1:0]   len_ff, len_in;
   syntax_state_type   syn_ff, syn_in;
   logic [COUNT_W-1:0] bytes_ff, bytes_in;
   logic               failed_ff, failed_in;
   logic [BANK_W-1:0]  bank_ff, bank_in;
   logic [BANKS-1:0]   busy_ff, busy_in;

   logic               accept;
   logic [COUNT_W:0]   dot_total;
   logic [COUNT_W:0]   end_total;
   logic               dot_over;
   logic               end_over;

   assign req.ready = !fifo_status.full && !busy_ff[bank_ff];
   assign accept    = req.valid && req.ready;

   always_comb begin
      dot_total = {1'b0, bytes_ff} + (COUNT_W + 1)'(len_ff) + (COUNT_W + 1)'(1);
      if (syn_ff == SYN_START) begin
         end_total = {1'b0, bytes_ff} + (COUNT_W + 1)'(1);
      end else begin
         end_total = {1'b0, bytes_ff} + (COUNT_W + 1)'(len_ff) + (COUNT_W + 1)'(2);
      end
      dot_over = dot_total > {1'b0, max_wire_ff};
      end_over = end_total > {1'b0, max_wire_ff};
   end

   always_comb begin
      len_in    = len_ff;
      syn_in    = syn_ff;
      bytes_in  = bytes_ff;
      failed_in = failed_ff;
      bank_in   = bank_ff;
      push      = 1'b0;
      push_cmd  = '{has_label: 1'b0, add_term: 1'b0, bank: bank_ff, len: len_ff,
                    err: ERR_NONE};
      ram_wr_en   = 1'b0;
      ram_wr_addr = {bank_ff, len_ff};
      ram_wr_data = req.char_byte;

      if (accept) begin
         if (req.end_marker) begin
            if (!failed_ff) begin
               push = 1'b1;
               if (syn_ff == SYN_HYPHEN) begin
                  push_cmd.err = ERR_SYNTAX;
               end else if (end_over) begin
                  push_cmd.err = ERR_LIMIT;
               end else begin
                  push_cmd.has_label = (syn_ff != SYN_START);
                  push_cmd.add_term  = 1'b1;
                  if (syn_ff != SYN_START) begin
                     bank_in = bank_ff + BANK_W'(1);
                  end
               end
            end
            // drop the name state for the next name
            len_in    = '0;
            syn_in    = SYN_START;
            bytes_in  = '0;
            failed_in = 1'b0;
         end else if (!failed_ff) begin
            if (req.char_byte == CHAR_DOT) begin
               push = 1'b1;
               if (syn_ff == SYN_START || syn_ff == SYN_HYPHEN) begin
                  push_cmd.err = ERR_SYNTAX;
                  failed_in    = 1'b1;
               end else if (dot_over) begin
                  push_cmd.err = ERR_LIMIT;
                  failed_in    = 1'b1;
               end else begin
                  push_cmd.has_label = 1'b1;
                  syn_in   = SYN_START;
                  bytes_in = dot_total[COUNT_W-1:0];
                  len_in   = '0;
                  bank_in  = bank_ff + BANK_W'(1);
               end
            end else if (!is_alnum(req.char_byte) &&
                         !(req.char_byte == CHAR_HYPHEN && syn_ff != SYN_START)) begin
               push         = 1'b1;
               push_cmd.err = ERR_SYNTAX;
               failed_in    = 1'b1;
            end else if (len_ff >= LEN_W'(LABEL_MAX)) begin
               push         = 1'b1;
               push_cmd.err = ERR_LONG;
               failed_in    = 1'b1;
            end else begin
               ram_wr_en = 1'b1;
               len_in    = len_ff + LEN_W'(1);
               if (req.char_byte == CHAR_HYPHEN) begin
                  syn_in = SYN_HYPHEN;
               end else if (syn_ff == SYN_START) begin
                  syn_in = SYN_FIRST;
               end else begin
                  syn_in = SYN_ALNUM;
               end
            end
         end
      end

      // a bank stays busy from its label command until the back has replayed it
      busy_in = busy_ff;
      if (release_bank.valid) begin
         busy_in[release_bank.bank] = 1'b0;
      end
      if (push && push_cmd.has_label) begin
         busy_in[bank_ff] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_wire_ff <= MAX_WIRE_RESET;
         len_ff      <= '0;
         syn_ff      <= SYN_START;
         bytes_ff    <= '0;
         failed_ff   <= 1'b0;
         bank_ff     <= '0;
         busy_ff     <= '0;
      end else begin
         if (csr_write_enable) begin
            max_wire_ff <= csr_write_data;
         end
         len_ff    <= len_in;
         syn_ff    <= syn_in;
         bytes_ff  <= bytes_in;
         failed_ff <= failed_in;
         bank_ff   <= bank_in;
         busy_ff   <= busy_in;
      end
   end

endmodule

`default_nettype wire

@@ hdl/hdwe_back.sv @@
// Back: pops commands, replays labels as length byte and characters, and emits terminator or error words.
`default_nettype none

module hdwe_back (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire hdwe_pkg::cmd_type               head_cmd,
   input  wire hdwe_pkg::fifo_status_type       fifo_status,
   output      logic                            pop,
   output      hdwe_pkg::bank_release_type      release_bank,
   output      logic                            ram_rd_en,
   output      logic [hdwe_pkg::RAM_ADDR_W-1:0] ram_rd_addr,
   input  wire logic [7:0]                      ram_rd_data,
   hdwe_rsp_if.source                           rsp
);
   import hdwe_pkg::*;

   back_state_type   state_ff, state_in;
   cmd_type          cmd_ff, cmd_in;
   logic [LEN_W-1:0] idx_ff, idx_in;
   logic [LEN_W-1:0] idx_next;

   logic             valid_ff, valid_in;
   logic [7:0]       byte_ff, byte_in;
   logic             last_ff, last_in;
   err_code_type     err_ff, err_in;

   logic             out_free;
   logic             load;

   assign out_free = !valid_ff || rsp.ready;
   assign idx_next = idx_ff + LEN_W'(1);

   always_comb begin
      state_in    = state_ff;
      cmd_in      = cmd_ff;
      idx_in      = idx_ff;
      pop         = 1'b0;
      load        = 1'b0;
      byte_in     = byte_ff;
      last_in     = last_ff;
      err_in      = err_ff;
      ram_rd_en   = 1'b0;
      ram_rd_addr = {cmd_ff.bank, idx_next};
      release_bank.valid = 1'b0;
      release_bank.bank  = cmd_ff.bank;

      case (state_ff)
         BK_IDLE: begin
            if (!fifo_status.empty) begin
               pop    = 1'b1;
               cmd_in = head_cmd;
               if (head_cmd.err != ERR_NONE) begin
                  state_in = BK_ERR;
               end else if (head_cmd.has_label) begin
                  state_in = BK_LEN;
               end else begin
                  state_in = BK_TERM;
               end
            end
         end
         BK_LEN: begin
            if (out_free) begin
               load        = 1'b1;
               byte_in     = 8'(cmd_ff.len);
               last_in     = 1'b0;
               err_in      = ERR_NONE;
               ram_rd_en   = 1'b1;
               ram_rd_addr = {cmd_ff.bank, LEN_W'(0)};
               idx_in      = '0;
               state_in    = BK_CHAR;
            end
         end
         BK_CHAR: begin
            // read data holds until the next read is issued
            if (out_free) begin
               load    = 1'b1;
               byte_in = ram_rd_data;
               last_in = 1'b0;
               err_in  = ERR_NONE;
               if (idx_next < cmd_ff.len) begin
                  ram_rd_en = 1'b1;
                  idx_in    = idx_next;
               end else begin
                  release_bank.valid = 1'b1;
                  state_in = cmd_ff.add_term ? BK_TERM : BK_IDLE;
               end
            end
         end
         BK_TERM: begin
            if (out_free) begin
               load     = 1'b1;
               byte_in  = 8'd0;
               last_in  = 1'b1;
               err_in   = ERR_NONE;
               state_in = BK_IDLE;
            end
         end
         BK_ERR: begin
            if (out_free) begin
               load     = 1'b1;
               byte_in  = 8'd0;
               last_in  = 1'b1;
               err_in   = cmd_ff.err;
               state_in = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase

      if (load) begin
         valid_in = 1'b1;
      end else if (rsp.ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff  <= cmd_in;
      idx_ff  <= idx_in;
      byte_ff <= byte_in;
      last_ff <= last_in;
      err_ff  <= err_in;
   end

   assign rsp.valid        = valid_ff;
   assign rsp.wire_byte    = byte_ff;
   assign rsp.last_of_name = last_ff;
   assign rsp.error_code   = err_ff;

endmodule

`default_nettype wire

@@ hdl/hostname_to_dns_wire_encoder_core.sv @@
// Top level: host name to DNS wire format encoder.
//
//   channel   direction  word contents
//   req_chan  in         char_byte, end_marker
//   rsp_chan  out        wire_byte, last_of_name, error_code
//   csr       in         csr_write_enable, csr_write_data (max_wire_bytes)
//
// A character word is written into the label RAM as it is taken; a dot or end word
// pushes a command that the back pops and replays as result bytes (length byte,
// characters, terminator), while the front can go on taking the next label.
// Labels are double-buffered in the label RAM; the front holds req_chan.ready low
// while the bank it would fill is still being replayed or the command queue is full.
// Reset is synchronous and clears all control state; max_wire_bytes resets to 255.
`default_nettype none

module hostname_to_dns_wire_encoder_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_write_enable,
   input  wire logic [11:0] csr_write_data,
   hdwe_req_if.sink         req_chan,
   hdwe_rsp_if.source       rsp_chan
);
   import hdwe_pkg::*;

   fifo_status_type        fifo_status;
   cmd_type                push_cmd;
   cmd_type                head_cmd;
   logic                   push;
   logic                   pop;
   bank_release_type       release_bank;
   logic                   ram_wr_en;
   logic [RAM_ADDR_W-1:0]  ram_wr_addr;
   logic [7:0]             ram_wr_data;
   logic                   ram_rd_en;
   logic [RAM_ADDR_W-1:0]  ram_rd_addr;
   logic [7:0]             ram_rd_data;

   hdwe_front u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req              (req_chan),
      .fifo_status      (fifo_status),
      .release_bank     (release_bank),
      .push             (push),
      .push_cmd         (push_cmd),
      .ram_wr_en        (ram_wr_en),
      .ram_wr_addr      (ram_wr_addr),
      .ram_wr_data      (ram_wr_data)
   );

   hdwe_cmd_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head_cmd (head_cmd),
      .status   (fifo_status)
   );

   hdwe_ram #(
      .WIDTH (8),
      .DEPTH (RAM_DEPTH)
   ) u_label_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   hdwe_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head_cmd     (head_cmd),
      .fifo_status  (fifo_status),
      .pop          (pop),
      .release_bank (release_bank),
      .ram_rd_en    (ram_rd_en),
      .ram_rd_addr  (ram_rd_addr),
      .ram_rd_data  (ram_rd_data),
      .rsp          (rsp_chan)
   );

endmodule

`default_nettype wire

@@ dv/testbench.sv @@
// Self-checking testbench for the host name to DNS wire format encoder core.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import hdwe_pkg::*;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_CYCLES = 16;
   localparam int LONG_HOLD    = 400;

   typedef struct packed {
      logic [7:0] ch;
      logic       fin;
   } name_word_type;

   typedef struct packed {
      logic [7:0] wbyte;
      logic       last;
      logic [1:0] err;
   } wire_word_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_we = 1'b0;
   logic [11:0] csr_wdata = '0;

   hdwe_req_if req_if ();
   hdwe_rsp_if rsp_if ();

   hostname_to_dns_wire_encoder_core dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_we),
      .csr_write_data   (csr_wdata),
      .req_chan         (req_if),
      .rsp_chan         (rsp_if)
   );

   // stimulus and expected output
   name_word_type name_words[$];
   wire_word_type wire_due[$];

   // encoder shadow state
   logic [7:0]       label_chars [LABEL_MAX];
   int               lab_len = 0;
   syntax_state_type syn = SYN_START;
   logic [11:0]      name_bytes = '0;
   logic             name_failed = 1'b0;
   logic [11:0]      wire_limit = MAX_WIRE_RESET;

   int  send_idle_pct = 23;
   int  recv_idle_pct = 60;
   bit  hold_trigger = 1'b0;
   bit  hold_seen = 1'b0;
   int  hold_left = 0;
   bit  req_fired = 1'b0;

   int  words_queued = 0;
   int  names_queued = 0;
   int  results_checked = 0;
   int  error_results = 0;
   int  mismatches = 0;
   int  cycle_count = 0;

   initial begin
      forever #4 clock = ~clock;
   end

   // ---------------------------------------------------------------- predictor

   task automatic due_push(input logic [7:0] b, input logic last, input err_code_type e);
      wire_word_type w;
      w = '{wbyte: b, last: last, err: e};
      wire_due.insert(wire_due.size(), w);
   endtask

   task automatic flag_error(input err_code_type e);
      name_failed = 1'b1;
      due_push(8'h00, 1'b1, e);
   endtask

   task automatic reset_name();
      lab_len = 0;
      syn = SYN_START;
      name_bytes = '0;
      name_failed = 1'b0;
   endtask

   task automatic emit_label();
      due_push(8'(lab_len), 1'b0, ERR_NONE);
      for (int i = 0; i < lab_len; i++)
         due_push(label_chars[i], 1'b0, ERR_NONE);
      name_bytes = name_bytes + 12'(lab_len) + 12'd1;
      lab_len = 0;
   endtask

   function automatic bit letter_or_digit(input logic [7:0] c);
      return (c >= CHAR_UP_A && c <= CHAR_UP_Z) || (c >= CHAR_LO_A && c <= CHAR_LO_Z) ||
             (c >= CHAR_0 && c <= CHAR_9);
   endfunction

   task automatic encode_word(input name_word_type w);
      int need;
      if (w.fin) begin
         if (name_failed) begin
            // drop quietly, just clear below
         end else if (syn == SYN_HYPHEN) begin
            flag_error(ERR_SYNTAX);
         end else begin
            need = 1;
            if (syn != SYN_START)
               need += lab_len + 1;
            if (int'(name_bytes) + need > int'(wire_limit)) begin
               flag_error(ERR_LIMIT);
            end else begin
               if (syn != SYN_START)
                  emit_label();
               due_push(8'h00, 1'b1, ERR_NONE);
            end
         end
         reset_name();
      end else if (!name_failed) begin
         if (w.ch == CHAR_DOT) begin
            if (syn == SYN_START || syn == SYN_HYPHEN)
               flag_error(ERR_SYNTAX);
            else if (int'(name_bytes) + lab_len + 1 > int'(wire_limit))
               flag_error(ERR_LIMIT);
            else begin
               syn = SYN_START;
               emit_label();
            end
         end else if (!letter_or_digit(w.ch) && !(w.ch == CHAR_HYPHEN && syn != SYN_START)) begin
            flag_error(ERR_SYNTAX);
         end else if (lab_len >= LABEL_MAX) begin
            flag_error(ERR_LONG);
         end else begin
            label_chars[lab_len] = w.ch;
            lab_len++;
            if (w.ch == CHAR_HYPHEN)
               syn = SYN_HYPHEN;
            else if (syn == SYN_START)
               syn = SYN_FIRST;
            else
               syn = SYN_ALNUM;
         end
      end
   endtask

   // ---------------------------------------------------------------- stimulus

   task automatic push_char(input logic [7:0] c);
      name_word_type w;
      w = '{ch: c, fin: 1'b0};
      name_words.insert(name_words.size(), w);
      words_queued++;
   endtask

   task automatic push_end();
      name_word_type w;
      w = '{ch: 8'($urandom_range(255)), fin: 1'b1};
      name_words.insert(name_words.size(), w);
      words_queued++;
      names_queued++;
   endtask

   task automatic push_name(input string s);
      for (int i = 0; i < s.len(); i++)
         push_char(s[i]);
      push_end();
   endtask

   function automatic logic [7:0] rand_alnum();
      int idx;
      idx = $urandom_range(61);
      if (idx < 26)
         return CHAR_UP_A + 8'(idx);
      else if (idx < 52)
         return CHAR_LO_A + 8'(idx - 26);
      return CHAR_0 + 8'(idx - 52);
   endfunction

   // well-formed label: letter or digit at both ends, hyphens inside
   task automatic push_label(input int len);
      for (int i = 0; i < len; i++) begin
         if (i != 0 && i != len - 1 && $urandom_range(4) == 0)
            push_char(CHAR_HYPHEN);
         else
            push_char(rand_alnum());
      end
   endtask

   task automatic push_random_names(input int count);
      int stop_at;
      int labels;
      int len;
      int pick;
      stop_at = words_queued + count;
      while (words_queued < stop_at) begin
         if ($urandom_range(99) < 80) begin
            labels = $urandom_range(1, 4);
            for (int i = 0; i < labels; i++) begin
               len = ($urandom_range(15) == 0) ? $urandom_range(40, LABEL_MAX + 1)
                                               : $urandom_range(1, 8);
               push_label(len);
               if (i < labels - 1 || $urandom_range(9) == 0)
                  push_char(CHAR_DOT);
            end
         end else begin
            repeat ($urandom_range(1, 6)) begin
               pick = $urandom_range(3);
               push_char(pick == 0 ? 8'($urandom_range(255)) :
                         pick == 1 ? CHAR_DOT :
                         pick == 2 ? CHAR_HYPHEN : rand_alnum());
            end
         end
         push_end();
      end
   endtask

   task automatic set_wire_limit(input logic [11:0] v);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_wdata <= v;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // wait for every queued word to go in and every expected word to come out
   task automatic drain();
      while (name_words.size() != 0 || req_if.valid || wire_due.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // ---------------------------------------------------------------- driver

   initial begin
      req_if.valid = 1'b0;
      req_if.char_byte = '0;
      req_if.end_marker = 1'b0;
      rsp_if.ready = 1'b0;
   end

   always @(negedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (!req_if.valid || req_fired) begin
         if (name_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_if.valid <= 1'b1;
            req_if.char_byte <= name_words[0].ch;
            req_if.end_marker <= name_words[0].fin;
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // receiver: random back-pressure plus one long hold on request
   always @(negedge clock) begin
      if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_if.ready <= 1'b0;
      end else if (hold_trigger && !hold_seen) begin
         hold_seen <= 1'b1;
         hold_left <= LONG_HOLD;
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // ---------------------------------------------------------------- monitor

   always @(posedge clock) begin
      wire_word_type got;
      wire_word_type want;
      if (reset) begin
         req_fired = 1'b0;
      end else begin
         if (csr_we)
            wire_limit = csr_wdata;
         req_fired = req_if.valid && req_if.ready;
         if (req_fired)
            encode_word(name_words.pop_front());
         if (rsp_if.valid && rsp_if.ready) begin
            got = '{wbyte: rsp_if.wire_byte, last: rsp_if.last_of_name,
                    err: rsp_if.error_code};
            results_checked++;
            if (got.err != ERR_NONE)
               error_results++;
            if (wire_due.size() == 0) begin
               mismatches++;
               $display("%0t: expected no word, got byte %h last %b err %0d", $realtime,
                        got.wbyte, got.last, got.err);
            end else begin
               want = wire_due.pop_front();
               if (got.wbyte !== want.wbyte || got.last !== want.last ||
                   got.err !== want.err) begin
                  mismatches++;
                  $display("%0t: expected byte %h last %b err %0d, got byte %h last %b err %0d",
                           $realtime, want.wbyte, want.last, want.err,
                           got.wbyte, got.last, got.err);
               end
            end
         end
      end
   end

   // ---------------------------------------------------------------- watchdog

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles, %0d words still expected", cycle_count,
               wire_due.size());
      $display("hostname_to_dns_wire_encoder_core: mismatch");
      $finish;
   end

   // ---------------------------------------------------------------- sequence

   initial begin
      repeat (9) @(negedge clock);
      reset <= 1'b0;

      // directed names at the reset limit
      push_name("z9.Za");
      push_end();                // empty name
      push_name("a.");           // trailing dot
      push_name(".x");           // leading dot
      push_name("-a");           // leading hyphen
      push_name("a-");           // trailing hyphen at end
      push_name("a-.b");         // trailing hyphen at dot
      push_name("a..b");         // empty label
      push_char(8'h00);
      push_end();
      // longest label, then a label one character too long
      push_label(LABEL_MAX);
      push_char(CHAR_DOT);
      push_label(LABEL_MAX + 1);
      push_end();
      drain();

      // narrowest limit: only the bare terminator fits
      set_wire_limit(12'd1);
      push_end();
      push_name("a");
      drain();

      send_idle_pct = 60;
      recv_idle_pct = 23;
      set_wire_limit(12'd4);
      push_name("ab");           // fits exactly
      push_name("ab.c");         // second label plus terminator overflow
      push_random_names(4);
      drain();

      // widest limit; hold the output long enough for the input to back up
      set_wire_limit(12'd4095);
      hold_trigger = 1'b1;
      push_name("a.b.c.d");
      drain();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      set_wire_limit(12'd255);
      push_random_names(4);
      drain();

      $display("covered %0d names in %0d words; %0d result words checked, %0d of them errors",
               names_queued, words_queued, results_checked, error_results);
      $display("limits 255, 1, 4 and 4095 with stalls on either side and one long output hold");
      if (mismatches == 0 && wire_due.size() == 0) begin
         $display("hostname_to_dns_wire_encoder_core: match");
      end else begin
         $display("%0d mismatches, %0d words never seen", mismatches, wire_due.size());
         $display("hostname_to_dns_wire_encoder_core: mismatch");
      end
      $finish;
   end

endmodule

@@ files.f @@
hdl/hdwe_pkg.sv
hdl/hdwe_req_if.sv
hdl/hdwe_rsp_if.sv
hdl/hdwe_ram.sv
hdl/hdwe_cmd_fifo.sv
hdl/hdwe_front.sv
hdl/hdwe_back.sv
hdl/hostname_to_dns_wire_encoder_core.sv
dv/testbench.sv
